// ===== rtl/graphic_lcd_draw_command_sequencer_assert.svh =====
// Assertion macros for the LCD command sequencer.
// Each macro expects clk and rst to be visible where it is used.
`ifndef GRAPHIC_LCD_DRAW_COMMAND_SEQUENCER_ASSERT_SVH
`define GRAPHIC_LCD_DRAW_COMMAND_SEQUENCER_ASSERT_SVH

// Property holds at every clock outside reset.
`define GLCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition never occurs outside reset.
`define GLCD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/glcd_pkg.sv =====
// ----------------------------------------------------------------------------
// glcd_pkg
// Types, command codes and register indexes for the LCD command sequencer.
// ----------------------------------------------------------------------------
package glcd_pkg;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_RASTER = 2'd1,
    KIND_CHAR   = 2'd2,
    KIND_BUFFER = 2'd3
  } kind_t;

  localparam logic [1:0] BUF_CHOICE_A    = 2'd0;
  localparam logic [1:0] BUF_CHOICE_B    = 2'd1;
  localparam logic [1:0] BUF_CHOICE_FLIP = 2'd2;

  localparam logic [2:0] CFG_ROW_BYTES   = 3'd0;
  localparam logic [2:0] CFG_GFX_START_A = 3'd1;
  localparam logic [2:0] CFG_GFX_START_B = 3'd2;
  localparam logic [2:0] CFG_TXT_START_A = 3'd3;
  localparam logic [2:0] CFG_TXT_START_B = 3'd4;

  localparam logic [7:0]  ROW_BYTES_RESET   = 8'd32;
  localparam logic [15:0] GFX_START_A_RESET = 16'd0;
  localparam logic [15:0] GFX_START_B_RESET = 16'd3072;
  localparam logic [15:0] TXT_START_A_RESET = 16'd2048;
  localparam logic [15:0] TXT_START_B_RESET = 16'd5120;

  localparam logic [7:0] CMD_SET_ADDRESS  = 8'h24;
  localparam logic [7:0] CMD_BIT_SET      = 8'hF8;
  localparam logic [7:0] CMD_DATA_WRITE   = 8'hC4;
  localparam logic [7:0] CMD_GRAPHIC_HOME = 8'h42;
  localparam logic [7:0] CMD_TEXT_HOME    = 8'h40;
  localparam logic [7:0] CHAR_OFFSET      = 8'h20;

  localparam int GLCD_QUEUE_DEPTH = 4;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  x_coord;
    logic [7:0]  y_coord;
    logic [7:0]  value;
    logic [1:0]  buffer_choice;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       last;
  } res_t;

  // Classified request: first address, second address (text home), data byte.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] addr_a;
    logic [15:0] addr_b;
    logic [7:0]  data;
  } entry_t;

  function automatic logic [2:0] last_step(kind_t k);
    logic [2:0] r;
    unique case (k)
      KIND_PIXEL:  r = 3'd3;
      KIND_RASTER: r = 3'd4;
      KIND_CHAR:   r = 3'd4;
      KIND_BUFFER: r = 3'd5;
      default:     r = 3'd5;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/glcd_front.sv =====
// ----------------------------------------------------------------------------
// glcd_front
// Holds configuration and the draw buffer, resolves each request's addresses.
// ----------------------------------------------------------------------------
module glcd_front
  import glcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        accept,
  input  req_t        req,
  output entry_t      entry
);

  logic [7:0]  row_bytes;
  logic [15:0] gfx_start_a;
  logic [15:0] gfx_start_b;
  logic [15:0] txt_start_a;
  logic [15:0] txt_start_b;
  logic        draw_buffer;
  logic        draw_buffer_next;
  logic        sel;
  logic [15:0] cur_g;
  logic [15:0] cur_t;
  logic [15:0] sel_g;
  logic [15:0] sel_t;
  logic [15:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes   <= ROW_BYTES_RESET;
      gfx_start_a <= GFX_START_A_RESET;
      gfx_start_b <= GFX_START_B_RESET;
      txt_start_a <= TXT_START_A_RESET;
      txt_start_b <= TXT_START_B_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROW_BYTES:   row_bytes   <= cfg_data[7:0];
        CFG_GFX_START_A: gfx_start_a <= cfg_data;
        CFG_GFX_START_B: gfx_start_b <= cfg_data;
        CFG_TXT_START_A: txt_start_a <= cfg_data;
        CFG_TXT_START_B: txt_start_b <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (req.buffer_choice == BUF_CHOICE_A) begin
      sel = 1'b0;
    end else if (req.buffer_choice == BUF_CHOICE_B) begin
      sel = 1'b1;
    end else begin
      sel = draw_buffer;
    end
    cur_g = draw_buffer ? gfx_start_b : gfx_start_a;
    cur_t = draw_buffer ? txt_start_b : txt_start_a;
    sel_g = sel ? gfx_start_b : gfx_start_a;
    sel_t = sel ? txt_start_b : txt_start_a;
    prod  = {8'd0, req.y_coord} * {8'd0, row_bytes};

    draw_buffer_next = draw_buffer;
    if (accept && req.kind == KIND_BUFFER) begin
      draw_buffer_next = (req.buffer_choice == BUF_CHOICE_FLIP) ? ~sel : sel;
    end

    entry.kind   = req.kind;
    entry.addr_b = sel_t;
    unique case (req.kind)
      KIND_PIXEL: begin
        entry.addr_a = prod + {11'd0, req.x_coord[7:3]} + cur_g;
        entry.data   = CMD_BIT_SET | {5'd0, ~req.x_coord[2:0]};
      end
      KIND_RASTER: begin
        entry.addr_a = prod + {11'd0, req.x_coord[7:3]} + cur_g;
        entry.data   = req.value;
      end
      KIND_CHAR: begin
        entry.addr_a = prod + {8'd0, req.x_coord} + cur_t;
        entry.data   = req.value - CHAR_OFFSET;
      end
      default: begin
        entry.addr_a = sel_g;
        entry.data   = req.value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_buffer <= 1'b0;
    end else begin
      draw_buffer <= draw_buffer_next;
    end
  end

endmodule

// ===== rtl/glcd_queue.sv =====
// ----------------------------------------------------------------------------
// glcd_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module glcd_queue
  import glcd_pkg::*;
#(
  parameter int DEPTH = GLCD_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  `include "graphic_lcd_draw_command_sequencer_assert.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `GLCD_NEVER(q_overflow, push && full && !pop, "queue push while full")
  `GLCD_NEVER(q_underflow, pop && !head_valid, "queue pop while empty")
  `GLCD_ASSERT(q_count_up, push && !pop |=> count == $past(count) + 1'b1, "queue count slip")

endmodule

// ===== rtl/glcd_back.sv =====
// ----------------------------------------------------------------------------
// glcd_back
// Steps through each classified request and drives the output byte register.
// ----------------------------------------------------------------------------
module glcd_back
  import glcd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   head_valid,
  input  entry_t head,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   out_data
);

  `include "graphic_lcd_draw_command_sequencer_assert.svh"

  entry_t     cur;
  logic       busy;
  logic [2:0] step;
  logic       load;
  logic       at_last;
  res_t       beat;

  assign load    = busy && (!out_valid || out_ready);
  assign at_last = (step == last_step(cur.kind));
  assign pop     = head_valid && (!busy || (load && at_last));

  always_comb begin
    beat.last = at_last;
    unique case (step)
      3'd0: begin
        beat.out_byte   = cur.addr_a[7:0];
        beat.is_command = 1'b0;
      end
      3'd1: begin
        beat.out_byte   = cur.addr_a[15:8];
        beat.is_command = 1'b0;
      end
      3'd2: begin
        beat.out_byte   = (cur.kind == KIND_BUFFER) ? CMD_GRAPHIC_HOME : CMD_SET_ADDRESS;
        beat.is_command = 1'b1;
      end
      3'd3: begin
        beat.out_byte   = (cur.kind == KIND_BUFFER) ? cur.addr_b[7:0] : cur.data;
        beat.is_command = (cur.kind == KIND_PIXEL);
      end
      3'd4: begin
        beat.out_byte   = (cur.kind == KIND_BUFFER) ? cur.addr_b[15:8] : CMD_DATA_WRITE;
        beat.is_command = (cur.kind != KIND_BUFFER);
      end
      3'd5: begin
        beat.out_byte   = CMD_TEXT_HOME;
        beat.is_command = 1'b1;
      end
      default: begin
        beat.out_byte   = '0;
        beat.is_command = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (load) begin
      out_data <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        step <= '0;
      end else if (load) begin
        busy <= !at_last;
        step <= step + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `GLCD_ASSERT(b_step_bound, busy |-> step <= last_step(cur.kind), "step past request end")
  `GLCD_ASSERT(b_last_end, load && beat.last |=> !busy || $past(pop), "last beat not closing")
  `GLCD_NEVER(b_pop_midway, busy && pop && !(load && at_last), "pop during a request")

endmodule

// ===== rtl/graphic_lcd_draw_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// graphic_lcd_draw_command_sequencer
// Draw requests in, tagged display controller bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one draw request per beat (set pixel,
//   raster byte, character, buffer select). out_valid/out_ready/out_data
//   carry one controller byte per beat with its command flag; last marks
//   the final byte of a request.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the row pitch and the four
//   base addresses; cfg_ready is always high. Write only while idle.
//   A request yields 4 (pixel), 5 (raster, character) or 6 (buffer) bytes,
//   one per cycle from the output register while the receiver is ready, as
//   set by the byte stepper in the back end. After acceptance a request
//   passes through the queue and the current-request register first.
//   The front resolves addresses on acceptance and queues up to
//   QUEUE_DEPTH requests, so it keeps accepting while the receiver stalls;
//   in_ready drops only when the queue is full.
//   Reset restores the register defaults and selects buffer A, empties the
//   queue and drops out_valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
module graphic_lcd_draw_command_sequencer
  import glcd_pkg::*;
#(
  parameter int QUEUE_DEPTH = GLCD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic   accept;
  logic   full;
  logic   pop;
  logic   head_valid;
  entry_t entry;
  entry_t head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;

  glcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .req       (in_data),
    .entry     (entry)
  );

  glcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  glcd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LCD draw command sequencer: directed and random
// draw requests under sender gaps and receiver stalls, with every controller
// byte compared against an in-bench prediction of the byte stream.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import glcd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SHOWN_MAX   = 40;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  res_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_ROW_BYTES;
  logic [15:0] cfg_data = '0;

  // predicted controller state
  logic [7:0]  row_pitch;
  logic [15:0] gfx_base [2];
  logic [15:0] txt_base [2];
  logic        draw_sel;
  res_t        due_bytes [$];

  rx_mode_t    rx_mode = RX_ALWAYS;
  int          hold_cnt = 0;
  int          rx_phase = 0;
  int          cycle_cnt = 0;
  int          fail_count = 0;
  int          shown = 0;
  int          reqs_accepted = 0;
  int          bytes_checked = 0;
  int          reg_writes = 0;

  graphic_lcd_draw_command_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void add_byte(input logic [7:0] b, input logic cmd);
    res_t e;
    e.out_byte   = b;
    e.is_command = cmd;
    e.last       = 1'b0;
    due_bytes.push_back(e);
  endfunction

  function automatic void add_address(input logic [15:0] a);
    add_byte(a[7:0], 1'b0);
    add_byte(a[15:8], 1'b0);
    add_byte(CMD_SET_ADDRESS, 1'b1);
  endfunction

  // Appends the byte stream one request produces and updates the buffer select.
  function automatic void compute_lcd_bytes(input req_t r);
    logic [15:0] addr;
    logic [15:0] gb;
    logic [15:0] tb;
    res_t        e;
    case (r.kind)
      KIND_PIXEL, KIND_RASTER: begin
        addr = 16'(int'(r.y_coord) * int'(row_pitch) + int'(r.x_coord >> 3)
                   + int'(gfx_base[draw_sel]));
        add_address(addr);
        if (r.kind == KIND_PIXEL) begin
          add_byte(CMD_BIT_SET | {5'd0, ~r.x_coord[2:0]}, 1'b1);
        end else begin
          add_byte(r.value, 1'b0);
          add_byte(CMD_DATA_WRITE, 1'b1);
        end
      end
      KIND_CHAR: begin
        addr = 16'(int'(r.y_coord) * int'(row_pitch) + int'(r.x_coord)
                   + int'(txt_base[draw_sel]));
        add_address(addr);
        add_byte(r.value - CHAR_OFFSET, 1'b0);
        add_byte(CMD_DATA_WRITE, 1'b1);
      end
      default: begin
        if (r.buffer_choice == BUF_CHOICE_A) begin
          draw_sel = 1'b0;
        end else if (r.buffer_choice == BUF_CHOICE_B) begin
          draw_sel = 1'b1;
        end
        gb = gfx_base[draw_sel];
        tb = txt_base[draw_sel];
        add_byte(gb[7:0], 1'b0);
        add_byte(gb[15:8], 1'b0);
        add_byte(CMD_GRAPHIC_HOME, 1'b1);
        add_byte(tb[7:0], 1'b0);
        add_byte(tb[15:8], 1'b0);
        add_byte(CMD_TEXT_HOME, 1'b1);
        if (r.buffer_choice == BUF_CHOICE_FLIP) begin
          draw_sel = ~draw_sel;
        end
      end
    endcase
    e = due_bytes.pop_back();
    e.last = 1'b1;
    due_bytes.push_back(e);
  endfunction

  // register writes and accepted requests feed the prediction
  always @(posedge clk) begin
    if (rst) begin
      row_pitch   = ROW_BYTES_RESET;
      gfx_base[0] = GFX_START_A_RESET;
      gfx_base[1] = GFX_START_B_RESET;
      txt_base[0] = TXT_START_A_RESET;
      txt_base[1] = TXT_START_B_RESET;
      draw_sel    = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          CFG_ROW_BYTES:   row_pitch   = cfg_data[7:0];
          CFG_GFX_START_A: gfx_base[0] = cfg_data;
          CFG_GFX_START_B: gfx_base[1] = cfg_data;
          CFG_TXT_START_A: txt_base[0] = cfg_data;
          CFG_TXT_START_B: txt_base[1] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        reqs_accepted++;
        compute_lcd_bytes(in_data);
      end
    end
  end

  task automatic report(input string what, input int unsigned want, input int unsigned got);
    fail_count++;
    if (shown < SHOWN_MAX) begin
      shown++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : byte_check
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_bytes.size() == 0) begin
        fail_count++;
        if (shown < SHOWN_MAX) begin
          shown++;
          $display("%0t: unexpected beat, expected none, got byte %0h cmd %0b last %0b",
                   $time, out_data.out_byte, out_data.is_command, out_data.last);
        end
      end else begin
        want = due_bytes.pop_front();
        bytes_checked++;
        if (out_data.out_byte !== want.out_byte)
          report("out_byte", want.out_byte, out_data.out_byte);
        if (out_data.is_command !== want.is_command)
          report("is_command", want.is_command, out_data.is_command);
        if (out_data.last !== want.last)
          report("last", want.last, out_data.last);
      end
    end
  end

  // receiver: long hold-off when armed, else the selected stall pattern
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  out_ready <= 1'b1;
        RX_RANDOM:  out_ready <= ($urandom_range(0, 99) < 65);
        default:    out_ready <= ((rx_phase % 11) < 7) && ((rx_phase % 11) != 2);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still due", cycle_cnt, due_bytes.size());
      $display("** graphic_lcd_draw_command_sequencer: FAILED **");
      $finish;
    end
  end

  function automatic req_t mk_req(input kind_t k, input logic [7:0] x, input logic [7:0] y,
                                  input logic [7:0] v, input logic [1:0] ch);
    req_t r;
    r.kind          = k;
    r.x_coord       = x;
    r.y_coord       = y;
    r.value         = v;
    r.buffer_choice = ch;
    return r;
  endfunction

  function automatic req_t rand_req();
    return mk_req(kind_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  2'($urandom_range(0, 3)));
  endfunction

  // leaves valid high; the caller either sends again or idles in the same step
  task automatic send_req(input req_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_idle(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drain();
    sender_idle(1);
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(input int count);
    int burst;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      send_req(rand_req());
      burst--;
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) sender_idle($urandom_range(1, 20));
        burst = $urandom_range(1, 30);
      end
    end
  endtask

  task automatic test_reset_defaults();
    rx_mode = RX_PATTERN;
    send_req(mk_req(KIND_PIXEL, 8'd0, 8'd0, 8'd0, BUF_CHOICE_A));
    send_req(mk_req(KIND_PIXEL, 8'd255, 8'd255, 8'd255, 2'd3));
    send_req(mk_req(KIND_PIXEL, 8'd5, 8'd1, 8'd0, BUF_CHOICE_A));
    send_req(mk_req(KIND_RASTER, 8'd0, 8'd0, 8'h00, BUF_CHOICE_A));
    send_req(mk_req(KIND_RASTER, 8'd255, 8'd255, 8'hFF, BUF_CHOICE_FLIP));
    send_req(mk_req(KIND_CHAR, 8'd0, 8'd0, 8'h00, BUF_CHOICE_A));
    send_req(mk_req(KIND_CHAR, 8'd255, 8'd255, 8'hFF, BUF_CHOICE_B));
    send_req(mk_req(KIND_CHAR, 8'd3, 8'd2, CHAR_OFFSET, BUF_CHOICE_A));
    send_req(mk_req(KIND_BUFFER, 8'hFF, 8'hFF, 8'hFF, BUF_CHOICE_B));
    send_req(mk_req(KIND_PIXEL, 8'd7, 8'd3, 8'd0, BUF_CHOICE_A));
    send_req(mk_req(KIND_BUFFER, 8'h00, 8'h00, 8'h00, BUF_CHOICE_FLIP));
    send_req(mk_req(KIND_CHAR, 8'd1, 8'd1, 8'h41, BUF_CHOICE_A));
    // choice three keeps the buffer and repeats its home addresses
    send_req(mk_req(KIND_BUFFER, 8'h55, 8'hAA, 8'h5A, 2'd3));
    send_req(mk_req(KIND_BUFFER, 8'h00, 8'h00, 8'h00, BUF_CHOICE_A));
    send_req(mk_req(KIND_RASTER, 8'hAA, 8'h55, 8'h5A, 2'd3));
    wait_drain();
  endtask

  task automatic test_config_extremes();
    rx_mode = RX_ALWAYS;
    write_reg(CFG_ROW_BYTES, 16'hFFFF);
    write_reg(CFG_GFX_START_A, 16'hFFFF);
    write_reg(CFG_GFX_START_B, 16'hFFFF);
    write_reg(CFG_TXT_START_A, 16'hFFFF);
    write_reg(CFG_TXT_START_B, 16'hFFFF);
    // address sums wrap past the top of memory
    send_req(mk_req(KIND_PIXEL, 8'd255, 8'd255, 8'd0, BUF_CHOICE_A));
    send_req(mk_req(KIND_CHAR, 8'd255, 8'd255, 8'h7F, BUF_CHOICE_A));
    send_req(mk_req(KIND_RASTER, 8'd9, 8'd200, 8'hC3, BUF_CHOICE_A));
    // flip with equal bases must still toggle the buffer
    send_req(mk_req(KIND_BUFFER, 8'd0, 8'd0, 8'd0, BUF_CHOICE_FLIP));
    wait_drain();
    write_reg(CFG_GFX_START_B, 16'h0000);
    write_reg(CFG_ROW_BYTES, 16'h0000);
    // zero pitch: every row lands on the same address
    send_req(mk_req(KIND_PIXEL, 8'd16, 8'd200, 8'd0, BUF_CHOICE_A));
    send_req(mk_req(KIND_RASTER, 8'd16, 8'd0, 8'h81, BUF_CHOICE_A));
    send_req(mk_req(KIND_CHAR, 8'd4, 8'd99, 8'h1F, BUF_CHOICE_A));
    send_req(mk_req(KIND_BUFFER, 8'd0, 8'd0, 8'd0, 2'd3));
    wait_drain();
  endtask

  task automatic test_backpressure();
    rx_mode = RX_RANDOM;
    hold_cnt <= 300;
    for (int i = 0; i < 16; i++) send_req(rand_req());
    wait_drain();
  endtask

  task automatic test_random();
    logic [7:0]  pitch;
    logic [15:0] base;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       pitch = 8'd1;
        1:       pitch = 8'd255;
        default: pitch = 8'($urandom_range(0, 255));
      endcase
      base = 16'($urandom_range(0, 65535));
      write_reg(CFG_ROW_BYTES, {8'($urandom_range(0, 255)), pitch});
      write_reg(CFG_GFX_START_A, base);
      write_reg(CFG_GFX_START_B, (ph == 3) ? base : 16'($urandom_range(0, 65535)));
      write_reg(CFG_TXT_START_A, 16'($urandom_range(0, 65535)));
      write_reg(CFG_TXT_START_B, 16'($urandom_range(0, 65535)));
      case (ph % 3)
        0:       rx_mode = RX_ALWAYS;
        1:       rx_mode = RX_RANDOM;
        default: rx_mode = RX_PATTERN;
      endcase
      send_random(64);
      wait_drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_backpressure();
    test_random();
    repeat (10) @(posedge clk);
    if (due_bytes.size() != 0) begin
      fail_count++;
      $display("%0t: %0d predicted bytes never arrived", $time, due_bytes.size());
    end
    $display("Checked %0d controller bytes from %0d draw requests, %0d register writes.",
             bytes_checked, reqs_accepted, reg_writes);
    $display("Pixel, raster, character and buffer requests with gaps, stalls and a hold-off.");
    if (fail_count == 0) begin
      $display("** graphic_lcd_draw_command_sequencer: PASSED **");
    end else begin
      $display("** graphic_lcd_draw_command_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== graphic_lcd_draw_command_sequencer.f =====
+incdir+rtl
rtl/glcd_pkg.sv
rtl/glcd_front.sv
rtl/glcd_queue.sv
rtl/glcd_back.sv
rtl/graphic_lcd_draw_command_sequencer.sv
tb/testbench.sv
